@@ hdl/ptk_pkg.sv @@
// Shared types and constants of the peak top-k selector.
`default_nettype none

package ptk_pkg;

    // Field widths fixed by the item format
    localparam int VAL_W = 31;
    localparam int SEL_W = 6;

    typedef logic [VAL_W-1:0] value_t;
    typedef logic [SEL_W-1:0] sel_t;

    // Commands from the sequencer to every cell of the chain
    typedef struct packed {
        logic clear;
        logic shift_dn;
        logic shift_up;
    } ptk_ctrl_t;

    // What the sequencer sees of the chain
    typedef struct packed {
        value_t head_value;
        value_t tail_value;
        logic   tail_valid;
        logic   landed;
    } ptk_stat_t;

endpackage

`default_nettype wire

@@ hdl/ptk_if.sv @@
// Channel interfaces of the peak top-k selector: samples, results and setup.
`default_nettype none

interface ptk_in_if import ptk_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t sample_value;
    logic   last_sample;

    modport source (output valid, sample_value, last_sample, input ready);
    modport sink (input valid, sample_value, last_sample, output ready);
endinterface

interface ptk_out_if import ptk_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t peak_value;
    logic   no_peaks;
    logic   last_of_run;

    modport source (output valid, peak_value, no_peaks, last_of_run, input ready);
    modport sink (input valid, peak_value, no_peaks, last_of_run, output ready);
endinterface

interface ptk_cfg_if import ptk_pkg::*; ();
    logic valid;
    logic ready;
    sel_t select_count;

    modport source (output valid, select_count, input ready);
    modport sink (input valid, select_count, output ready);
endinterface

`default_nettype wire

@@ hdl/ptk_cell.sv @@
// One cell of the sorted peak chain: holds one entry and passes a carry on.
`default_nettype none

module ptk_cell import ptk_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ptk_ctrl_t ctrl,
    input  wire logic      in_vld,
    input  wire value_t    in_val,
    input  wire logic      prev_vld,
    input  wire value_t    prev_val,
    input  wire logic      next_vld,
    input  wire value_t    next_val,
    output logic           valid,
    output value_t         value,
    output logic           carry_vld,
    output value_t         carry_val,
    output logic           land
);

    logic   valid_reg, valid_next;
    value_t value_reg, value_next;
    logic   cvld_reg, cvld_next;
    value_t cval_reg, cval_next;

    // Clear, shift, or insert, drop duplicate, swap or pass the carried value
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        cvld_next  = 1'b0;
        cval_next  = cval_reg;
        land       = 1'b0;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_dn)
        begin
            valid_next = next_vld;
            value_next = next_val;
        end
        else if (ctrl.shift_up)
        begin
            valid_next = prev_vld;
            value_next = prev_val;
        end
        else if (in_vld)
        begin
            priority if (!valid_reg)
            begin
                valid_next = 1'b1;
                value_next = in_val;
                land       = 1'b1;
            end
            else if (in_val == value_reg)
            begin
                cvld_next = 1'b0;
            end
            else if (in_val > value_reg)
            begin
                value_next = in_val;
                cval_next  = value_reg;
                cvld_next  = 1'b1;
            end
            else
            begin
                cval_next = in_val;
                cvld_next = 1'b1;
            end
        end
        else
        begin
            // Hold the entry, nothing to carry
            cvld_next = 1'b0;
        end
    end

    // Hold control bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cvld_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            cvld_reg  <= cvld_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        cval_reg  <= cval_next;
    end

    assign valid     = valid_reg;
    assign value     = value_reg;
    assign carry_vld = cvld_reg;
    assign carry_val = cval_reg;

endmodule

`default_nettype wire

@@ hdl/ptk_seq.sv @@
// Sequencer: peak detection, chain control, report and result register.
`default_nettype none

module ptk_seq import ptk_pkg::*;
#(
    parameter int MAX_K = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    ptk_in_if.sink         samples,
    ptk_out_if.source      peaks,
    ptk_cfg_if.sink        cfg,
    input  wire ptk_stat_t stat,
    output ptk_ctrl_t      ctrl,
    output logic           ins_vld,
    output value_t         ins_val
);

    localparam int CW = $clog2(MAX_K + 1);
    localparam int XW = (CW > SEL_W) ? CW : SEL_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FINAL   = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_ALIGN   = 3'd3;
    localparam logic [2:0] S_EMIT_DN = 3'd4;
    localparam logic [2:0] S_EMIT_UP = 3'd5;
    localparam logic [2:0] S_NOPEAK  = 3'd6;
    localparam logic [2:0] S_CLEAR   = 3'd7;

    logic [2:0]    state_reg, state_next;
    value_t        older_reg, older_next;
    value_t        newer_reg, newer_next;
    value_t        fin_val_reg, fin_val_next;
    logic          fin_pk_reg, fin_pk_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] drain_reg, drain_next;
    logic [CW-1:0] rem_reg, rem_next;
    sel_t          sel_reg;
    logic          out_vld_reg, out_vld_next;
    value_t        out_val_reg, out_val_next;
    logic          out_np_reg, out_np_next;
    logic          out_last_reg, out_last_next;

    logic          slot_free;
    logic          accept;
    logic [XW-1:0] sel_x;
    logic [XW-1:0] k_x;
    logic [CW-1:0] k_c;

    // Clamp the requested count to the chain length
    assign sel_x = XW'(sel_reg);
    assign k_x   = (sel_x > XW'(MAX_K)) ? XW'(MAX_K) : sel_x;
    assign k_c   = CW'(k_x);

    assign slot_free     = !out_vld_reg || peaks.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    // Next-state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        older_next    = older_reg;
        newer_next    = newer_reg;
        fin_val_next  = fin_val_reg;
        fin_pk_next   = fin_pk_reg;
        cnt_next      = cnt_reg + CW'(stat.landed);
        drain_next    = drain_reg;
        rem_next      = rem_reg;
        out_vld_next  = out_vld_reg && !peaks.ready;
        out_val_next  = out_val_reg;
        out_np_next   = out_np_reg;
        out_last_next = out_last_reg;
        ctrl          = '0;
        ins_vld       = 1'b0;
        ins_val       = newer_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ins_vld    = (older_reg < newer_reg) && (newer_reg > samples.sample_value);
                    older_next = newer_reg;
                    newer_next = samples.sample_value;
                    if (samples.last_sample)
                    begin
                        // Final sample faces zero on its right
                        fin_val_next = samples.sample_value;
                        fin_pk_next  = newer_reg < samples.sample_value;
                        older_next   = '0;
                        newer_next   = '0;
                        state_next   = S_FINAL;
                    end
                end
            end
            S_FINAL:
            begin
                ins_vld    = fin_pk_reg;
                ins_val    = fin_val_reg;
                drain_next = CW'(MAX_K);
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (drain_reg != '0)
                begin
                    drain_next = drain_reg - CW'(1);
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_NOPEAK;
                end
                else if (cnt_reg >= k_c)
                begin
                    rem_next   = k_c;
                    state_next = (k_c == '0) ? S_CLEAR : S_EMIT_DN;
                end
                else
                begin
                    rem_next   = cnt_reg;
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                // Push entries to the tail so the smallest sits in the last cell
                if (stat.tail_valid)
                begin
                    state_next = S_EMIT_UP;
                end
                else
                begin
                    ctrl.shift_up = 1'b1;
                end
            end
            S_EMIT_DN, S_EMIT_UP:
            begin
                if (slot_free)
                begin
                    out_vld_next  = 1'b1;
                    out_val_next  = (state_reg == S_EMIT_DN) ? stat.head_value
                                                             : stat.tail_value;
                    out_np_next   = 1'b0;
                    out_last_next = (rem_reg == CW'(1));
                    ctrl.shift_dn = (state_reg == S_EMIT_DN);
                    ctrl.shift_up = (state_reg == S_EMIT_UP);
                    rem_next      = rem_reg - CW'(1);
                    if (rem_reg == CW'(1))
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_NOPEAK:
            begin
                if (slot_free)
                begin
                    out_vld_next  = 1'b1;
                    out_val_next  = '0;
                    out_np_next   = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                ctrl.clear = 1'b1;
                cnt_next   = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            older_reg   <= '0;
            newer_reg   <= '0;
            cnt_reg     <= '0;
            drain_reg   <= '0;
            rem_reg     <= '0;
            fin_pk_reg  <= 1'b0;
            sel_reg     <= SEL_W'(1);
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            cnt_reg     <= cnt_next;
            drain_reg   <= drain_next;
            rem_reg     <= rem_next;
            fin_pk_reg  <= fin_pk_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid)
            begin
                sel_reg <= cfg.select_count;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        fin_val_reg  <= fin_val_next;
        out_val_reg  <= out_val_next;
        out_np_reg   <= out_np_next;
        out_last_reg <= out_last_next;
    end

    assign peaks.valid       = out_vld_reg;
    assign peaks.peak_value  = out_val_reg;
    assign peaks.no_peaks    = out_np_reg;
    assign peaks.last_of_run = out_last_reg;

endmodule

`default_nettype wire

@@ hdl/peak_top_k_distinct_selector.sv @@
// Top level of the peak top-k selector: sequencer and sorted cell chain.
`default_nettype none

// Takes one sample per cycle while a sequence streams in. Each detected peak
// enters a chain of MAX_K cells at the head and ripples down one cell per
// cycle, landing in order, dropping on a duplicate and pushing smaller entries
// toward the tail; several peaks may be in flight at once. After the last
// sample the block takes no samples: it inserts the final peak, lets the chain
// settle, then gives one result per cycle the output side accepts (descending
// reports shift the chain toward the head; ascending reports first shift it
// toward the tail), then clears the chain before the next sample is taken.
// select_count may be written only between sequences.
module peak_top_k_distinct_selector import ptk_pkg::*;
#(
    parameter int MAX_K = 32
)
(
    input wire logic  clk,
    input wire logic  rst_n,
    ptk_in_if.sink    samples,
    ptk_out_if.source peaks,
    ptk_cfg_if.sink   cfg
);

    ptk_ctrl_t        ctrl;
    ptk_stat_t        stat;
    logic             ins_vld;
    value_t           ins_val;
    logic   [MAX_K-1:0] vld_w;
    value_t [MAX_K-1:0] val_w;
    logic   [MAX_K-1:0] cvld_w;
    value_t [MAX_K-1:0] cval_w;
    logic   [MAX_K-1:0] land_w;

    ptk_seq #(.MAX_K(MAX_K)) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .peaks   (peaks),
        .cfg     (cfg),
        .stat    (stat),
        .ctrl    (ctrl),
        .ins_vld (ins_vld),
        .ins_val (ins_val)
    );

    // Build the chain of cells
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        logic   in_vld;
        value_t in_val;
        logic   prev_vld;
        value_t prev_val;
        logic   next_vld;
        value_t next_val;

        if (i == 0)
        begin : g_head
            assign in_vld   = ins_vld;
            assign in_val   = ins_val;
            assign prev_vld = 1'b0;
            assign prev_val = '0;
        end
        else
        begin : g_body
            assign in_vld   = cvld_w[i-1];
            assign in_val   = cval_w[i-1];
            assign prev_vld = vld_w[i-1];
            assign prev_val = val_w[i-1];
        end

        if (i == MAX_K - 1)
        begin : g_tail
            assign next_vld = 1'b0;
            assign next_val = '0;
        end
        else
        begin : g_inner
            assign next_vld = vld_w[i+1];
            assign next_val = val_w[i+1];
        end

        ptk_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_vld    (in_vld),
            .in_val    (in_val),
            .prev_vld  (prev_vld),
            .prev_val  (prev_val),
            .next_vld  (next_vld),
            .next_val  (next_val),
            .valid     (vld_w[i]),
            .value     (val_w[i]),
            .carry_vld (cvld_w[i]),
            .carry_val (cval_w[i]),
            .land      (land_w[i])
        );
    end

    // Report chain ends to the sequencer
    assign stat.head_value = val_w[0];
    assign stat.tail_value = val_w[MAX_K-1];
    assign stat.tail_valid = vld_w[MAX_K-1];
    assign stat.landed     = |land_w;

    // A peak enters the chain only while it is not being shifted or cleared
    a_ins_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ins_vld |-> !ctrl.shift_dn && !ctrl.shift_up && !ctrl.clear)
        else $error("peak inserted while chain shifts or clears");

    // At most one chain command per cycle
    a_ctrl_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.clear, ctrl.shift_dn, ctrl.shift_up}))
        else $error("conflicting chain commands");

    // At most one entry lands per cycle
    a_land_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(land_w))
        else $error("two entries landed in one cycle");

    // A no-peak result stands alone with a zero value
    a_nopeak: assert property (@(posedge clk) disable iff (!rst_n)
        peaks.valid && peaks.no_peaks |-> peaks.last_of_run && (peaks.peak_value == '0))
        else $error("malformed no-peak result");

endmodule

`default_nettype wire

@@ tb/peak_top_k_distinct_selector_tb.sv @@
// Self-checking testbench for the peak top-k distinct selector.
`timescale 1ns / 100ps

module peak_top_k_distinct_selector_tb;
    import ptk_pkg::*;

    localparam int MAX_K = 32;
    // Covers the last sample, chain settle, shift for an ascending report, clear, margin
    localparam int SETTLE_CYCLES = 3 * MAX_K + 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_REPORTED = 10;
    localparam int PHASE_SAMPLES = 50;
    localparam int LONG_SEQ_LEN = 72;

    typedef struct {
        value_t value;
        logic   last;
    } sample_req_t;

    typedef struct {
        value_t value;
        logic   no_peaks;
        logic   last;
    } peak_res_t;

    typedef enum int {
        SHAPE_ZIGZAG,
        SHAPE_NARROW,
        SHAPE_WIDE,
        SHAPE_RAMP,
        SHAPE_BITS
    } seq_shape_t;

    logic clk = 1'b0;
    logic rst_n;

    ptk_in_if  samples_ch ();
    ptk_out_if peaks_ch ();
    ptk_cfg_if cfg_ch ();

    peak_top_k_distinct_selector #(
        .MAX_K(MAX_K)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_ch),
        .peaks(peaks_ch),
        .cfg(cfg_ch)
    );

    sample_req_t pending_samples[$];
    peak_res_t   expected_peaks[$];

    // Predicted sequence state and select setting
    value_t prev_sample;
    value_t cur_sample;
    logic   seen_sample;
    value_t kept_peaks[MAX_K];
    int     kept_count;
    sel_t   select_now;

    int mismatch_count;
    int samples_sent;
    int sequences_sent;
    int results_checked;
    int settings_written;
    int idle_cycles;

    // Sender burst state and receiver stall pattern
    int   burst_left;
    int   gap_left;
    logic [15:0] ready_pattern;
    int   pattern_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_sequence();
        prev_sample = '0;
        cur_sample = '0;
        seen_sample = 1'b0;
        kept_count = 0;
    endfunction

    // Insert a peak into the descending list, drop duplicates, keep the MAX_K largest
    function automatic void keep_peak(value_t p);
        int slot;
        int i;
        slot = kept_count;
        for (i = 0; i < kept_count; i++)
            if (kept_peaks[i] == p)
                return;
        for (i = 0; i < kept_count; i++)
        begin
            if (p > kept_peaks[i])
            begin
                slot = i;
                break;
            end
        end
        if (slot >= MAX_K)
            return;
        for (i = (kept_count < MAX_K) ? kept_count : MAX_K - 1; i > slot; i--)
            kept_peaks[i] = kept_peaks[i - 1];
        kept_peaks[slot] = p;
        if (kept_count < MAX_K)
            kept_count++;
    endfunction

    // Advance the peak window by one sample; on the last sample queue the report
    function automatic void predict_peaks(sample_req_t req);
        int take;
        int i;
        peak_res_t res;
        if (seen_sample && prev_sample < cur_sample && cur_sample > req.value)
            keep_peak(cur_sample);
        prev_sample = seen_sample ? cur_sample : '0;
        cur_sample = req.value;
        seen_sample = 1'b1;
        if (!req.last)
            return;

        // The final sample faces a zero on its right
        if (prev_sample < cur_sample && cur_sample > 0)
            keep_peak(cur_sample);

        take = (select_now < MAX_K) ? int'(select_now) : MAX_K;
        res.no_peaks = 1'b0;
        if (kept_count == 0)
        begin
            res.value = '0;
            res.no_peaks = 1'b1;
            res.last = 1'b1;
            expected_peaks.push_back(res);
        end
        else if (kept_count >= take)
        begin
            for (i = 0; i < take; i++)
            begin
                res.value = kept_peaks[i];
                res.last = (i == take - 1);
                expected_peaks.push_back(res);
            end
        end
        else
        begin
            for (i = 0; i < kept_count; i++)
            begin
                res.value = kept_peaks[kept_count - 1 - i];
                res.last = (i == kept_count - 1);
                expected_peaks.push_back(res);
            end
        end
        restart_sequence();
    endfunction

    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("%0t ns: %s", $time, msg);
    endfunction

    task automatic queue_sample(value_t v, logic last);
        sample_req_t req;
        req.value = v;
        req.last = last;
        pending_samples.push_back(req);
        if (last)
            sequences_sent++;
    endtask

    task automatic queue_sequence(int len, seq_shape_t shape);
        int i;
        int b;
        logic rising;
        value_t v;
        rising = 1'($urandom_range(0, 1));
        for (i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_ZIGZAG: v = (i % 2) ? value_t'($urandom_range(32'h7FFF_FFFF, 16))
                                          : value_t'($urandom_range(15, 0));
                SHAPE_NARROW: v = value_t'($urandom_range(7, 0));
                SHAPE_WIDE:   v = value_t'($urandom());
                SHAPE_RAMP:   v = rising ? value_t'(i + 1) : value_t'(len - i);
                default:
                begin
                    b = $urandom_range(VAL_W - 1, 0);
                    v = $urandom_range(1, 0) ? (value_t'(1) << b) : ~(value_t'(1) << b);
                end
            endcase
            queue_sample(v, i == len - 1);
        end
    endtask

    // Queue a phase of sequences: mostly short, a few long, an optional opening long zigzag
    task automatic fill_random_phase(int item_goal, int long_len);
        int queued;
        int len;
        int roll;
        seq_shape_t shape;
        queued = 0;
        if (long_len > 0)
        begin
            queue_sequence(long_len, SHAPE_ZIGZAG);
            queued += long_len;
        end
        while (queued < item_goal)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
            roll = $urandom_range(0, 9);
            if (roll < 3)
                shape = SHAPE_ZIGZAG;
            else if (roll < 6)
                shape = SHAPE_NARROW;
            else if (roll < 8)
                shape = SHAPE_WIDE;
            else if (roll < 9)
                shape = SHAPE_RAMP;
            else
                shape = SHAPE_BITS;
            queue_sequence(len, shape);
            queued += len;
        end
    endtask

    // Hold off until every request is sent and every result is back, then let the block settle
    task automatic wait_until_drained();
        while (pending_samples.size() != 0 || expected_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_select(sel_t k);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.select_count <= k;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        select_now = k;
        settings_written++;
    endtask

    // Drive sample requests in bursts; hold a request until it is taken
    always @(posedge clk)
    begin : sample_driver
        logic drive_valid;
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                predict_peaks(pending_samples.pop_front());
                samples_sent++;
            end
            if (samples_ch.valid && !samples_ch.ready)
                drive_valid = 1'b1;
            else
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    drive_valid = 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    drive_valid = 1'b1;
                    burst_left--;
                    samples_ch.sample_value <= pending_samples[0].value;
                    samples_ch.last_sample <= pending_samples[0].last;
                end
                else
                    drive_valid = 1'b0;
            end
            samples_ch.valid <= drive_valid;
        end
    end

    // Check each result against the oldest expectation; stall on a rotating pattern
    always @(posedge clk)
    begin : result_check
        peak_res_t got;
        peak_res_t want;
        if (!rst_n)
        begin
            peaks_ch.ready <= 1'b0;
            pattern_left = 0;
            ready_pattern = '1;
        end
        else
        begin
            if (peaks_ch.valid && peaks_ch.ready)
            begin
                got.value = peaks_ch.peak_value;
                got.no_peaks = peaks_ch.no_peaks;
                got.last = peaks_ch.last_of_run;
                results_checked++;
                if (expected_peaks.size() == 0)
                    log_mismatch($sformatf("unexpected result: value %0d no_peaks %0b last %0b",
                                           got.value, got.no_peaks, got.last));
                else
                begin
                    want = expected_peaks.pop_front();
                    if (got.value !== want.value || got.no_peaks !== want.no_peaks
                        || got.last !== want.last)
                        log_mismatch($sformatf({"result mismatch: expected value %0d no_peaks %0b",
                                                " last %0b, got value %0d no_peaks %0b last %0b"},
                                               want.value, want.no_peaks, want.last,
                                               got.value, got.no_peaks, got.last));
                end
            end
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'hAAAA;
                    2:       ready_pattern = 16'h0FFF;
                    default: ready_pattern = 16'($urandom()) | 16'h0101;
                endcase
                pattern_left = 64;
            end
            pattern_left--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            peaks_ch.ready <= ready_pattern[0];
        end
    end

    // Drop the run if no request moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (samples_ch.valid && samples_ch.ready)
            || (peaks_ch.valid && peaks_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no request accepted for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int p;
        sel_t k;
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.sample_value = '0;
        samples_ch.last_sample = 1'b0;
        peaks_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.select_count = '0;
        restart_sequence();
        select_now = sel_t'(1);
        mismatch_count = 0;
        samples_sent = 0;
        sequences_sent = 0;
        results_checked = 0;
        settings_written = 0;
        idle_cycles = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset select of one: zero sample, full-scale single sample, flat run,
        // repeated equal peaks
        queue_sample('0, 1'b1);
        queue_sample(value_t'(31'h7FFF_FFFF), 1'b1);
        queue_sample(value_t'(5), 1'b0);
        queue_sample(value_t'(5), 1'b0);
        queue_sample(value_t'(5), 1'b1);
        queue_sample(value_t'(3), 1'b0);
        queue_sample(value_t'(1), 1'b0);
        queue_sample(value_t'(3), 1'b0);
        queue_sample(value_t'(1), 1'b0);
        queue_sample(value_t'(3), 1'b1);
        wait_until_drained();

        // Directed, select of three: fewer peaks (ascending), then more peaks (descending)
        write_select(sel_t'(3));
        queue_sample(value_t'(1), 1'b0);
        queue_sample(value_t'(9), 1'b0);
        queue_sample(value_t'(2), 1'b0);
        queue_sample(value_t'(7), 1'b0);
        queue_sample(value_t'(0), 1'b1);
        queue_sample(value_t'(4), 1'b0);
        queue_sample(value_t'(0), 1'b0);
        queue_sample(value_t'(8), 1'b0);
        queue_sample(value_t'(0), 1'b0);
        queue_sample(value_t'(6), 1'b0);
        queue_sample(value_t'(0), 1'b0);
        queue_sample(value_t'(2), 1'b0);
        queue_sample(value_t'(1), 1'b1);

        // Random phases, each under its own select setting
        for (p = 0; p < 7; p++)
        begin
            case (p)
                0:       k = sel_t'(MAX_K);
                1:       k = '1;
                2:       k = '0;
                3:       k = sel_t'(1);
                5:       k = sel_t'(40);
                default: k = sel_t'($urandom_range(2, MAX_K - 1));
            endcase
            wait_until_drained();
            write_select(k);
            fill_random_phase(PHASE_SAMPLES, (p < 2) ? LONG_SEQ_LEN : 0);
        end
        wait_until_drained();

        $display("Sent %0d samples in %0d sequences under %0d select settings;",
                 samples_sent, sequences_sent, settings_written);
        $display("checked %0d results, mismatches: %0d (no-peak, duplicate, ascending, %s",
                 results_checked, mismatch_count, "descending and overflow runs).");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
